// File: sv/sidiv_pkg.sv
package sidiv_pkg;

    // Operand and quotient width.
    localparam int DATA_WIDTH = 32;

    // Width of the step counter that walks the quotient bits.
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;

    // Bit positions of the flags in the result tuser.
    localparam int TUSER_OVF = 0;
    localparam int TUSER_DBZ = 1;

    // Largest positive quotient, used when the result saturates.
    localparam logic [DATA_WIDTH-1:0] QUOT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } sidiv_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } sidiv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_step;
    } sidiv_status_t;

endpackage

// File: sv/signed_int_divider_saturating.sv
// Channel   Direction  Handshake            Payload
// s_axis    in         s_tvalid / s_tready  s_tdata = {divisor, dividend}
// m_axis    out        m_tvalid / m_tready  m_tdata = quotient,
//                                           m_tuser = {divide_by_zero, overflow}
//
// A transaction is accepted only after the last one is through: a load, the
// restoring divide loop with one step per quotient bit (DATA_WIDTH), and a
// write that signs and saturates the quotient into the result register.
// Reset is asynchronous and active low; it returns the controller to idle
// and empties the result register.
// A stalled result waits in its register while the next dividend and
// divisor are taken and divided; only the final write waits for it.
module signed_int_divider_saturating
    import sidiv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] dividend, [63:32] divisor
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] quotient
    output logic [M_TUSER_W-1:0] m_tuser    // [0] overflow, [1] divide_by_zero
);

    sidiv_cmd_t            cmd;
    sidiv_status_t         status;
    logic [DATA_WIDTH-1:0] quotient;
    logic                  overflow;
    logic                  divide_by_zero;

    // Sequencing of load, divide steps and result write.
    sidiv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Magnitudes, shift-and-subtract loop and signed result.
    sidiv_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .dividend       (s_tdata[DATA_WIDTH-1:0]),
        .divisor        (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .quotient       (quotient),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

    // Pack the result transaction.
    assign m_tdata            = M_TDATA_W'(quotient);
    assign m_tuser[TUSER_OVF] = overflow;
    assign m_tuser[TUSER_DBZ] = divide_by_zero;

endmodule

// File: sv/sidiv_dp.sv
module sidiv_dp
    import sidiv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sidiv_cmd_t            cmd,
    output sidiv_status_t         status,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic                  overflow,
    output logic                  divide_by_zero
);

    // Working registers: the dividend magnitude shifts out at the top while
    // quotient bits shift in at the bottom of the same register.
    logic [DATA_WIDTH-1:0] work_reg, work_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic                  neg_reg, neg_next;
    logic                  dbz_reg, dbz_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // Result register, held until the result transaction completes.
    logic [DATA_WIDTH-1:0] quot_reg, quot_next;
    logic                  ovf_reg, ovf_next;
    logic                  dbzo_reg, dbzo_next;

    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH-1:0] rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // Magnitudes of the operands; the most negative value maps to 2^(W-1).
    assign mag_a = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign mag_b = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;

    // One restoring step: the remainder stays below the divisor, so its top
    // bit is always clear before the shift.
    assign rem_shift = {rem_reg[DATA_WIDTH-2:0], work_reg[DATA_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {1'b0, dvs_reg};
    assign fits      = ~diff[DATA_WIDTH];

    assign status.last_step = (cnt_reg == '0);

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        dbz_next  = dbz_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        dbzo_next = dbzo_reg;

        if (cmd.load)
        begin
            work_next = mag_a;
            rem_next  = '0;
            dvs_next  = mag_b;
            neg_next  = dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
            dbz_next  = (divisor == '0);
            cnt_next  = CNT_W'(DATA_WIDTH - 1);
        end

        if (cmd.step)
        begin
            work_next = {work_reg[DATA_WIDTH-2:0], fits};
            rem_next  = fits ? diff[DATA_WIDTH-1:0] : rem_shift;
            cnt_next  = cnt_reg - 1'b1;
        end

        // Apply the sign, saturate, and flag the special cases.
        if (cmd.finish)
        begin
            ovf_next  = 1'b0;
            dbzo_next = 1'b0;
            if (dbz_reg)
            begin
                quot_next = '0;
                dbzo_next = 1'b1;
            end
            else if (neg_reg)
            begin
                quot_next = ~work_reg + 1'b1;
            end
            else if (work_reg[DATA_WIDTH-1])
            begin
                quot_next = QUOT_MAX;
                ovf_next  = 1'b1;
            end
            else
            begin
                quot_next = work_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        dbz_reg  <= dbz_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
        dbzo_reg <= dbzo_next;
    end

    assign quotient       = quot_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dbzo_reg;

endmodule

// File: sv/sidiv_ctrl.sv
module sidiv_ctrl
    import sidiv_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output sidiv_cmd_t    cmd,
    input  sidiv_status_t status
);

    sidiv_state_t state_reg, state_next;
    logic         mvalid_reg, mvalid_next;
    logic         out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = ~mvalid_reg | m_tready;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        mvalid_next = mvalid_reg & ~m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

endmodule

// File: test/divide_result_check.sv
module divide_result_check
    import sidiv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] dividend, [63:32] divisor
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [31:0] quotient
    input  logic [M_TUSER_W-1:0] m_tuser,   // [0] overflow, [1] divide_by_zero
    output int                   error_count,
    output int                   quotients_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic                  overflow;
        logic                  divide_by_zero;
    } quot_result_t;

    quot_result_t expected_quotients[$];
    int           mismatch_total;

    // Truncating signed division on the magnitudes, with the sign applied
    // afterwards and the one unrepresentable quotient saturated.
    function automatic quot_result_t divide_saturate(
        input logic [DATA_WIDTH-1:0] num,
        input logic [DATA_WIDTH-1:0] den
    );
        quot_result_t          res;
        logic [DATA_WIDTH-1:0] num_mag;
        logic [DATA_WIDTH-1:0] den_mag;
        logic [DATA_WIDTH-1:0] q_mag;
        res = '0;
        if (den == '0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        // The most negative value has magnitude 2^(N-1), which still fits unsigned.
        num_mag = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : num;
        den_mag = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : den;
        q_mag   = num_mag / den_mag;
        if (num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1])
            res.quotient = DATA_WIDTH'(-q_mag);
        else if (q_mag > QUOT_MAX)
        begin
            res.quotient = QUOT_MAX;
            res.overflow = 1'b1;
        end
        else
            res.quotient = q_mag;
        return res;
    endfunction

    initial
    begin
        mismatch_total = 0;
    end

    // Compare each result transaction with the oldest prediction, then
    // predict for each accepted operand transaction.
    always @(posedge clk)
    begin
        quot_result_t want;
        quot_result_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.quotient       = m_tdata[DATA_WIDTH-1:0];
                got.overflow       = m_tuser[TUSER_OVF];
                got.divide_by_zero = m_tuser[TUSER_DBZ];
                if (expected_quotients.size() == 0)
                begin
                    $display("%0t: unexpected result: quotient %0d, flags ovf=%0b dbz=%0b",
                             $time, $signed(got.quotient), got.overflow, got.divide_by_zero);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_quotients.pop_front();
                    if (got.quotient !== want.quotient)
                    begin
                        $display("%0t: quotient mismatch: expected %0d, got %0d", $time,
                                 $signed(want.quotient), $signed(got.quotient));
                        mismatch_total++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow mismatch: expected %0b, got %0b", $time,
                                 want.overflow, got.overflow);
                        mismatch_total++;
                    end
                    if (got.divide_by_zero !== want.divide_by_zero)
                    begin
                        $display("%0t: divide_by_zero mismatch: expected %0b, got %0b", $time,
                                 want.divide_by_zero, got.divide_by_zero);
                        mismatch_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_quotients.push_back(divide_saturate(s_tdata[DATA_WIDTH-1:0],
                                                             s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
        end
        error_count       <= mismatch_total;
        quotients_pending <= expected_quotients.size();
    end

endmodule

// File: test/tb.sv
module tb;
    import sidiv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS  = QUOT_MAX;
    localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;
    localparam int                    RANDOM_DIVISIONS = 1500;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] dividend, [63:32] divisor
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [31:0] quotient
    logic [M_TUSER_W-1:0] m_tuser;   // [0] overflow, [1] divide_by_zero
    int                   error_count;
    int                   quotients_pending;
    bit                   steady;

    signed_int_divider_saturating dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    divide_result_check u_result_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .error_count       (error_count),
        .quotients_pending (quotients_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one dividend/divisor transaction after a random gap, or none in steady mode.
    task automatic offer_division(input logic [DATA_WIDTH-1:0] num,
                                  input logic [DATA_WIDTH-1:0] den);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({den, num});
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // Operands weighted toward small values, extremes and zero.
    function automatic logic [DATA_WIDTH-1:0] draw_operand();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(0, 9)) inside
            [0:3]: v = DATA_WIDTH'($urandom);
            [4:5]: v = DATA_WIDTH'(int'($urandom_range(0, 40)) - 20);
            6:
            begin
                case ($urandom_range(0, 4))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = '0;
                    3:       v = 1;
                    default: v = MINUS_ONE;
                endcase
            end
            default:
            begin
                v = DATA_WIDTH'($urandom) >> $urandom_range(1, DATA_WIDTH - 1);
                if ($urandom_range(0, 1) == 1)
                    v = DATA_WIDTH'(-v);
            end
        endcase
        return v;
    endfunction

    // Result side: random stalls (none in steady mode), plus one long hold-off so the block backs up.
    initial
    begin
        int wait_cycles;
        int taken;
        bit held_off;
        taken    = 0;
        held_off = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && taken == 300)
            begin
                wait_cycles = 400;
                held_off    = 1'b1;
            end
            else
                wait_cycles = steady ? 0 : $urandom_range(0, 3);
            repeat (wait_cycles)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // Reset, directed corner cases, random divisions, then the verdict.
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Most negative dividend, saturation, zero divisor and sign combinations.
        offer_division(MOST_NEG, MINUS_ONE);
        offer_division(MOST_NEG, 1);
        offer_division(MOST_NEG, MOST_NEG);
        offer_division(MOST_NEG, 2);
        offer_division(MOST_NEG, MOST_POS);
        offer_division(MOST_POS, MOST_NEG);
        offer_division(MOST_POS, 1);
        offer_division(MOST_POS, MINUS_ONE);
        offer_division(MOST_POS, MOST_POS);
        offer_division(12345, 0);
        offer_division(0, 0);
        offer_division(MOST_NEG, 0);
        offer_division(MINUS_ONE, 0);
        offer_division(0, 5);
        offer_division(0, MOST_NEG);
        offer_division(7, 2);
        offer_division(DATA_WIDTH'(-7), 2);
        offer_division(7, DATA_WIDTH'(-2));
        offer_division(DATA_WIDTH'(-7), DATA_WIDTH'(-2));
        offer_division(MINUS_ONE, MINUS_ONE);
        offer_division(MINUS_ONE, MOST_NEG);
        offer_division(1, MOST_POS);
        offer_division(5, MINUS_ONE);

        for (int i = 0; i < RANDOM_DIVISIONS; i++)
        begin
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            offer_division(draw_operand(), draw_operand());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        steady   = 1'b0;

        while (quotients_pending != 0) @(negedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
